@@ design/linear_classifier_confusion_macros.svh @@
// Assertion macros shared by the classifier RTL
`ifndef LINEAR_CLASSIFIER_CONFUSION_MACROS_SVH
`define LINEAR_CLASSIFIER_CONFUSION_MACROS_SVH

// check cons in the same cycle as ante
`define LCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define LCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lcc_pkg.sv @@
// Shared constants, types and helpers of the linear classifier block
package lcc_pkg;

  localparam int NUM_CLASSES    = 16;
  localparam int NUM_FEATURES   = 1024;
  localparam int FEATURE_WIDTH  = 16;
  localparam int WEIGHT_WIDTH   = 16;
  localparam int COUNT_WIDTH    = 20;
  localparam int SCORE_WIDTH    = 44;
  localparam int FEAT_FRAC_BITS = 8;
  localparam int PROD_WIDTH     = FEATURE_WIDTH + WEIGHT_WIDTH;
  localparam int BIAS_WIDTH     = WEIGHT_WIDTH + FEAT_FRAC_BITS;
  localparam int CLASS_W        = 4;
  localparam int ROW_W          = 11;
  localparam int KIN_W          = 5;
  localparam int WT_ROWS        = NUM_FEATURES + 1;
  localparam int CELL_W         = 2 * CLASS_W;
  localparam int CELLS          = NUM_CLASSES * NUM_CLASSES;
  localparam int FIFO_DEPTH     = 16;
  localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

  localparam logic [KIN_W-1:0]       CLASS_COUNT_RESET = KIN_W'(10);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX         = '1;
  localparam logic [ROW_W-1:0]       LAST_POS          = ROW_W'(NUM_FEATURES);

  typedef enum logic [1:0] {
    OP_WRITE_WEIGHT = 2'd0,
    OP_FEATURE      = 2'd1,
    OP_READ_CELL    = 2'd2,
    OP_CLEAR        = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LABEL = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef logic signed [SCORE_WIDTH-1:0] score_t;

  typedef struct packed {
    logic [CLASS_W-1:0]     predicted_class;
    logic                   prediction_valid;
    logic                   correct;
    logic [COUNT_WIDTH-1:0] cell_count;
    logic [COUNT_WIDTH-1:0] row_total;
    logic [COUNT_WIDTH-1:0] correct_total;
    logic [COUNT_WIDTH-1:0] sample_total;
    status_t                status;
  } out_item_t;

  // clamp the class count register to the supported range
  function automatic logic [KIN_W-1:0] classes_in_use(input logic [KIN_W-1:0] k);
    logic [KIN_W-1:0] r;
    if (k < KIN_W'(2)) begin
      r = KIN_W'(2);
    end else if (k > KIN_W'(NUM_CLASSES)) begin
      r = KIN_W'(NUM_CLASSES);
    end else begin
      r = k;
    end
    return r;
  endfunction

  // saturating increment
  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_WIDTH'(1);
  endfunction

endpackage

@@ design/lcc_if.sv @@
// Input and result channel interfaces of the linear classifier block
interface lcc_in_if import lcc_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [ROW_W-1:0]                feature_index;
  logic [CLASS_W-1:0]              weight_class;
  logic signed [WEIGHT_WIDTH-1:0]  weight_value;
  logic signed [FEATURE_WIDTH-1:0] feature_value;
  logic                            last_feature;
  logic [CLASS_W-1:0]              label;
  logic [CLASS_W-1:0]              read_true_class;
  logic [CLASS_W-1:0]              read_predicted_class;

  modport source (
    output valid, opcode, feature_index, weight_class, weight_value, feature_value,
           last_feature, label, read_true_class, read_predicted_class,
    input  ready
  );
  modport sink (
    input  valid, opcode, feature_index, weight_class, weight_value, feature_value,
           last_feature, label, read_true_class, read_predicted_class,
    output ready
  );
endinterface

interface lcc_out_if import lcc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CLASS_W-1:0]     predicted_class;
  logic                   prediction_valid;
  logic                   correct;
  logic [COUNT_WIDTH-1:0] cell_count;
  logic [COUNT_WIDTH-1:0] row_total;
  logic [COUNT_WIDTH-1:0] correct_total;
  logic [COUNT_WIDTH-1:0] sample_total;
  logic [1:0]             status;

  modport source (
    output valid, predicted_class, prediction_valid, correct, cell_count, row_total,
           correct_total, sample_total, status,
    input  ready
  );
  modport sink (
    input  valid, predicted_class, prediction_valid, correct, cell_count, row_total,
           correct_total, sample_total, status,
    output ready
  );
endinterface

@@ design/lcc_argmax.sv @@
// Two-stage registered argmax tree over the class scores, lowest index wins ties
module lcc_argmax import lcc_pkg::*; (
  input  logic               clk,
  input  score_t             scores [NUM_CLASSES],
  input  logic [KIN_W-1:0]   kin,
  output logic [CLASS_W-1:0] pred
);

  localparam int GROUP      = 4;
  localparam int NUM_GROUPS = NUM_CLASSES / GROUP;

  typedef struct packed {
    logic               ok;
    logic [CLASS_W-1:0] idx;
    score_t             score;
  } cand_t;

  // lo has the lower index: take hi only when strictly larger
  function automatic cand_t pick(input cand_t lo, input cand_t hi);
    cand_t r;
    if (hi.ok && (!lo.ok || ($signed(hi.score) > $signed(lo.score)))) begin
      r = hi;
    end else begin
      r = lo;
    end
    return r;
  endfunction

  function automatic cand_t pick4(input cand_t a, input cand_t b, input cand_t c,
                                  input cand_t d);
    return pick(pick(a, b), pick(c, d));
  endfunction

  cand_t lane [NUM_CLASSES];
  cand_t grp_nxt [NUM_GROUPS];
  cand_t grp_r [NUM_GROUPS];
  cand_t best_nxt;
  cand_t best_r;

  always_comb begin
    for (int i = 0; i < NUM_CLASSES; i++) begin
      lane[i].ok    = (KIN_W'(i) < kin);
      lane[i].idx   = CLASS_W'(i);
      lane[i].score = scores[i];
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_nxt[g] = pick4(lane[g*GROUP], lane[g*GROUP+1], lane[g*GROUP+2],
                         lane[g*GROUP+3]);
    end
    best_nxt = pick4(grp_r[0], grp_r[1], grp_r[2], grp_r[3]);
  end

  always_ff @(posedge clk) begin
    grp_r  <= grp_nxt;
    best_r <= best_nxt;
  end

  assign pred = best_r.idx;

endmodule

@@ design/lcc_fifo.sv @@
// Result queue between the count stage and the result channel
module lcc_fifo import lcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t din,
  input  logic      pop,
  output logic      not_empty,
  output out_item_t dout
);

  out_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;
  logic [FIFO_AW:0]   count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (FIFO_AW+1)'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  assign not_empty = (count_r != '0);
  assign dout      = mem[rd_ptr_r];

endmodule

@@ design/linear_classifier_confusion.sv @@
// Top level: linear classifier with argmax and confusion counts
//
//   channel   direction  handshake            payload
//   in_ch     in         valid/ready          opcode, weight write, feature, label, read cell
//   out_ch    out        valid/ready          prediction, read counts, totals, status
//   cfg_*     in         cfg_we, no wait      class_count
//
// One item per cycle sustained while in_ch.ready is high. The weight row is read on the
// accepting edge; multiply, score add, two argmax levels, count read and count update
// follow as registered steps in that order.
// The score add closes a loop that accumulates the scores feature by feature.
// Reset is synchronous; the weight table is not cleared, confusion cells clear through
// valid bits at once, so there is no clearing pass.
// A 16-entry result queue takes the stall; in_ch.ready drops once 16 items are in flight.
`include "linear_classifier_confusion_macros.svh"
module linear_classifier_confusion import lcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [KIN_W-1:0] cfg_wdata,
  lcc_in_if.sink           in_ch,
  lcc_out_if.source        out_ch
);

  typedef struct packed {
    opcode_t            op;
    logic               feat;
    logic               first;
    logic               last;
    logic [CLASS_W-1:0] label;
    logic [CLASS_W-1:0] rd_row;
    logic [CLASS_W-1:0] rd_col;
    status_t            status;
  } ctl_t;

  typedef struct packed {
    opcode_t            op;
    logic               pvalid;
    logic [CLASS_W-1:0] pred;
    logic               correct;
    logic               count;
    logic               read_ok;
    logic [CELL_W-1:0]  caddr;
    status_t            status;
  } res_ctl_t;

  // configuration and flow control
  logic [KIN_W-1:0]   cfg_r;
  logic [KIN_W-1:0]   kin;
  logic [FIFO_AW:0]   outstanding_r;
  logic [FIFO_AW:0]   outstanding_nxt;
  logic               in_acc;
  logic               out_acc;

  // accept stage
  opcode_t            op_in;
  logic               wr_ok;
  logic               ovf;
  logic [ROW_W-1:0]   pos_r;
  logic [ROW_W-1:0]   pos_nxt;
  logic [ROW_W-1:0]   rd_addr;
  ctl_t               p1_nxt;

  // pipeline control
  logic               p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r, p6_v_r;
  logic [5:0]         stage_v;
  ctl_t               p1_r, p2_r, p3_r, p4_r, p5_r;
  res_ctl_t           p6_nxt;
  res_ctl_t           p6_r;

  // datapath
  logic signed [FEATURE_WIDTH-1:0] fval1_r;
  logic signed [WEIGHT_WIDTH-1:0]  wrow_r [NUM_CLASSES];
  logic signed [WEIGHT_WIDTH-1:0]  bias1_r [NUM_CLASSES];
  logic signed [WEIGHT_WIDTH-1:0]  bias2_r [NUM_CLASSES];
  logic signed [PROD_WIDTH-1:0]    prod_r [NUM_CLASSES];
  score_t                          base_c [NUM_CLASSES];
  logic [SCORE_WIDTH:0]            sum_c [NUM_CLASSES];
  score_t                          score_nxt [NUM_CLASSES];
  score_t                          score_r [NUM_CLASSES];
  logic [CLASS_W-1:0]              pred5;

  // count stage
  logic                   is_sample;
  logic                   lab_ok;
  logic                   rd_ok;
  logic [CELL_W-1:0]      caddr_nxt;
  logic [COUNT_WIDTH-1:0] cmem [CELLS];
  logic [CELLS-1:0]       cvalid_r;
  logic [COUNT_WIDTH-1:0] crd_r;
  logic                   cvld_rd_r;
  logic                   hit_r;
  logic [COUNT_WIDTH-1:0] fwd_r;
  logic [COUNT_WIDTH-1:0] cell_cur;
  logic [COUNT_WIDTH-1:0] cell_bumped;
  logic                   cwe;
  logic                   clr6;
  logic [CLASS_W-1:0]     row6;
  logic [COUNT_WIDTH-1:0] row_tot_r [NUM_CLASSES];
  logic [COUNT_WIDTH-1:0] row_cur;
  logic [COUNT_WIDTH-1:0] sample_cnt_r;
  logic [COUNT_WIDTH-1:0] sample_cnt_nxt;
  logic [COUNT_WIDTH-1:0] correct_cnt_r;
  logic [COUNT_WIDTH-1:0] correct_cnt_nxt;
  out_item_t              res_item;
  out_item_t              q_item;
  logic                   q_not_empty;

  assign kin     = classes_in_use(cfg_r);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (outstanding_r < (FIFO_AW+1)'(FIFO_DEPTH));

  always_comb begin
    outstanding_nxt = outstanding_r;
    if (in_acc && !out_acc) begin
      outstanding_nxt = outstanding_r + (FIFO_AW+1)'(1);
    end else if (!in_acc && out_acc) begin
      outstanding_nxt = outstanding_r - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r         <= CLASS_COUNT_RESET;
      outstanding_r <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      outstanding_r <= outstanding_nxt;
    end
  end

  // ---------------- accept stage ----------------
  assign op_in   = opcode_t'(in_ch.opcode);
  assign wr_ok   = (op_in == OP_WRITE_WEIGHT) && (in_ch.feature_index <= LAST_POS);
  assign ovf     = (pos_r >= LAST_POS);
  assign rd_addr = pos_r + ROW_W'(1);

  always_comb begin
    pos_nxt = pos_r;
    if (in_acc && (op_in == OP_FEATURE)) begin
      if (ovf || in_ch.last_feature) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + ROW_W'(1);
      end
    end

    p1_nxt.op     = op_in;
    p1_nxt.feat   = (op_in == OP_FEATURE) && !ovf;
    p1_nxt.first  = (pos_r == '0);
    p1_nxt.last   = in_ch.last_feature;
    p1_nxt.label  = in_ch.label;
    p1_nxt.rd_row = in_ch.read_true_class;
    p1_nxt.rd_col = in_ch.read_predicted_class;
    if ((op_in == OP_WRITE_WEIGHT) && !wr_ok) begin
      p1_nxt.status = ST_BAD_INDEX;
    end else if ((op_in == OP_FEATURE) && ovf) begin
      p1_nxt.status = ST_OVERFLOW;
    end else begin
      p1_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
      p6_v_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      p1_v_r <= in_acc;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      p5_v_r <= p4_v_r;
      p6_v_r <= p5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r    <= p1_nxt;
    fval1_r <= in_ch.feature_value;
    p2_r    <= p1_r;
    p3_r    <= p2_r;
    p4_r    <= p3_r;
    p5_r    <= p4_r;
    p6_r    <= p6_nxt;
  end

  // weight table: one memory per class lane, read at the next row and at the bias row
  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_wlane
    logic signed [WEIGHT_WIDTH-1:0] wmem [WT_ROWS];

    always_ff @(posedge clk) begin
      if (in_acc && wr_ok && (in_ch.weight_class == CLASS_W'(g))) begin
        wmem[in_ch.feature_index] <= in_ch.weight_value;
      end
      wrow_r[g]  <= wmem[rd_addr];
      bias1_r[g] <= wmem[0];
    end
  end

  // ---------------- multiply stage ----------------
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      prod_r[c]  <= fval1_r * wrow_r[c];
      bias2_r[c] <= bias1_r[c];
    end
  end

  // ---------------- score stage ----------------
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (p2_r.first) begin
        base_c[c] = $signed({{(SCORE_WIDTH-BIAS_WIDTH){bias2_r[c][WEIGHT_WIDTH-1]}},
                             bias2_r[c], {FEAT_FRAC_BITS{1'b0}}});
      end else begin
        base_c[c] = score_r[c];
      end
      sum_c[c] = {base_c[c][SCORE_WIDTH-1], base_c[c]} +
                 {{(SCORE_WIDTH+1-PROD_WIDTH){prod_r[c][PROD_WIDTH-1]}}, prod_r[c]};
      // saturate when the two top bits disagree
      if (sum_c[c][SCORE_WIDTH] != sum_c[c][SCORE_WIDTH-1]) begin
        score_nxt[c] = sum_c[c][SCORE_WIDTH] ? $signed({1'b1, {(SCORE_WIDTH-1){1'b0}}})
                                             : $signed({1'b0, {(SCORE_WIDTH-1){1'b1}}});
      end else begin
        score_nxt[c] = $signed(sum_c[c][SCORE_WIDTH-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p2_v_r && p2_r.feat) begin
      score_r <= score_nxt;
    end
  end

  // ---------------- argmax stages ----------------
  lcc_argmax u_argmax (
    .clk    (clk),
    .scores (score_r),
    .kin    (kin),
    .pred   (pred5)
  );

  // ---------------- count read stage ----------------
  assign is_sample = p5_r.feat && p5_r.last;
  assign lab_ok    = ({1'b0, p5_r.label} < kin);
  assign rd_ok     = ({1'b0, p5_r.rd_row} < kin) && ({1'b0, p5_r.rd_col} < kin);
  assign caddr_nxt = (p5_r.op == OP_READ_CELL) ? {p5_r.rd_row, p5_r.rd_col}
                                               : {p5_r.label, pred5};

  always_comb begin
    p6_nxt.op      = p5_r.op;
    p6_nxt.pvalid  = is_sample;
    p6_nxt.pred    = is_sample ? pred5 : '0;
    p6_nxt.count   = is_sample && lab_ok;
    p6_nxt.correct = is_sample && lab_ok && (p5_r.label == pred5);
    p6_nxt.read_ok = (p5_r.op == OP_READ_CELL) && rd_ok;
    p6_nxt.caddr   = caddr_nxt;
    if (is_sample && !lab_ok) begin
      p6_nxt.status = ST_BAD_LABEL;
    end else if ((p5_r.op == OP_READ_CELL) && !rd_ok) begin
      p6_nxt.status = ST_BAD_INDEX;
    end else begin
      p6_nxt.status = p5_r.status;
    end
  end

  // forward the update of the item one stage ahead, which lands on this same edge
  always_ff @(posedge clk) begin
    crd_r     <= cmem[caddr_nxt];
    cvld_rd_r <= cvalid_r[caddr_nxt];
    hit_r     <= clr6 || (cwe && (p6_r.caddr == caddr_nxt));
    fwd_r     <= clr6 ? '0 : cell_bumped;
    if (cwe) begin
      cmem[p6_r.caddr] <= cell_bumped;
    end
  end

  // ---------------- count update stage ----------------
  assign cwe         = p6_v_r && p6_r.count;
  assign clr6        = p6_v_r && (p6_r.op == OP_CLEAR);
  assign cell_cur    = hit_r ? fwd_r : (cvld_rd_r ? crd_r : '0);
  assign cell_bumped = bump(cell_cur);
  assign row6        = p6_r.caddr[CELL_W-1 -: CLASS_W];
  assign row_cur     = row_tot_r[row6];

  always_comb begin
    sample_cnt_nxt  = sample_cnt_r;
    correct_cnt_nxt = correct_cnt_r;
    if (clr6) begin
      sample_cnt_nxt  = '0;
      correct_cnt_nxt = '0;
    end else if (cwe) begin
      sample_cnt_nxt = bump(sample_cnt_r);
      if (p6_r.correct) begin
        correct_cnt_nxt = bump(correct_cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r      <= '0;
      sample_cnt_r  <= '0;
      correct_cnt_r <= '0;
      for (int r = 0; r < NUM_CLASSES; r++) begin
        row_tot_r[r] <= '0;
      end
    end else begin
      sample_cnt_r  <= sample_cnt_nxt;
      correct_cnt_r <= correct_cnt_nxt;
      if (clr6) begin
        cvalid_r <= '0;
        for (int r = 0; r < NUM_CLASSES; r++) begin
          row_tot_r[r] <= '0;
        end
      end else if (cwe) begin
        cvalid_r[p6_r.caddr] <= 1'b1;
        row_tot_r[row6]      <= bump(row_cur);
      end
    end
  end

  always_comb begin
    res_item.predicted_class  = p6_r.pred;
    res_item.prediction_valid = p6_r.pvalid;
    res_item.correct          = p6_r.correct;
    res_item.cell_count       = p6_r.read_ok ? cell_cur : '0;
    res_item.row_total        = p6_r.read_ok ? row_cur : '0;
    res_item.correct_total    = correct_cnt_nxt;
    res_item.sample_total     = sample_cnt_nxt;
    res_item.status           = p6_r.status;
  end

  lcc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (p6_v_r),
    .din       (res_item),
    .pop       (out_acc),
    .not_empty (q_not_empty),
    .dout      (q_item)
  );

  assign out_ch.valid            = q_not_empty;
  assign out_ch.predicted_class  = q_item.predicted_class;
  assign out_ch.prediction_valid = q_item.prediction_valid;
  assign out_ch.correct          = q_item.correct;
  assign out_ch.cell_count       = q_item.cell_count;
  assign out_ch.row_total        = q_item.row_total;
  assign out_ch.correct_total    = q_item.correct_total;
  assign out_ch.sample_total     = q_item.sample_total;
  assign out_ch.status           = q_item.status;

  assign stage_v = {p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r, p6_v_r};

  `LCC_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= LAST_POS, "feature position past the last row")
  `LCC_ASSERT_NOW(a_inflight, 1'b1, $countones(stage_v) <= outstanding_r, "stage lost from count")
  `LCC_ASSERT_NOW(a_pop_owned, out_acc, outstanding_r != '0, "result taken with none outstanding")
  `LCC_ASSERT_NOW(a_corr_le_samp, 1'b1, correct_cnt_r <= sample_cnt_r, "correct above samples")
  `LCC_ASSERT_NEXT(a_clear_zero, clr6, sample_cnt_r == '0, "sample count not cleared")

endmodule

@@ tb/sv/linear_classifier_confusion_tb.sv @@
// Self-checking testbench for the linear classifier with confusion counts
module linear_classifier_confusion_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcc_pkg::*;

  typedef struct {
    opcode_t                         opcode;
    logic [ROW_W-1:0]                feature_index;
    logic [CLASS_W-1:0]              weight_class;
    logic signed [WEIGHT_WIDTH-1:0]  weight_value;
    logic signed [FEATURE_WIDTH-1:0] feature_value;
    logic                            last_feature;
    logic [CLASS_W-1:0]              label;
    logic [CLASS_W-1:0]              read_true_class;
    logic [CLASS_W-1:0]              read_predicted_class;
  } cmd_t;

  localparam longint SCORE_HI = (longint'(1) <<< (SCORE_WIDTH - 1)) - 1;
  localparam longint SCORE_LO = -SCORE_HI - 1;
  localparam int     QUIET_LIMIT = 3000;
  // samples never reach past position 6, so rows 0 to 7 cover every weight read
  localparam int     LOADED_ROWS = 8;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [KIN_W-1:0] cfg_wdata = '0;

  lcc_in_if  in_ch ();
  lcc_out_if out_ch ();

  linear_classifier_confusion i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #1ns clk = ~clk;

  // classifier state mirrored by the testbench
  logic signed [WEIGHT_WIDTH-1:0] weights [WT_ROWS*NUM_CLASSES];
  longint                         scores [NUM_CLASSES];
  int                             feat_pos;
  logic [COUNT_WIDTH-1:0]         confusion [CELLS];
  logic [COUNT_WIDTH-1:0]         row_tot [NUM_CLASSES];
  logic [COUNT_WIDTH-1:0]         n_correct;
  logic [COUNT_WIDTH-1:0]         n_samples;
  logic [KIN_W-1:0]               class_count_shadow;

  cmd_t      feed_q [$];
  out_item_t outcome_q [$];
  cmd_t      drive_cmd;
  int        items_unaccepted;
  int        gen_pos;
  int        send_gap;
  int        hold_left;
  int        quiet;
  int        errors;
  bit        idle_on;
  bit        long_hold_req;

  function automatic int classes_now();
    int k;
    k = class_count_shadow;
    if (k < 2) k = 2;
    if (k > NUM_CLASSES) k = NUM_CLASSES;
    return k;
  endfunction

  function automatic longint sat_score(input longint v);
    if (v > SCORE_HI) return SCORE_HI;
    if (v < SCORE_LO) return SCORE_LO;
    return v;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_counts();
    foreach (confusion[i]) confusion[i] = '0;
    foreach (row_tot[i]) row_tot[i] = '0;
    n_correct = '0;
    n_samples = '0;
  endfunction

  // apply one accepted item to the mirrored state and queue its result
  function automatic void classify(input cmd_t c);
    out_item_t r;
    int        kin;
    int        base;
    int        best;
    int        lab;
    longint    f;
    r = '0;
    r.status = ST_OK;
    kin = classes_now();
    case (c.opcode)
      OP_WRITE_WEIGHT: begin
        if (c.feature_index > NUM_FEATURES) begin
          r.status = ST_BAD_INDEX;
        end else begin
          weights[c.feature_index * NUM_CLASSES + c.weight_class] = c.weight_value;
        end
      end
      OP_FEATURE: begin
        if (feat_pos >= NUM_FEATURES) begin
          feat_pos = 0;
          r.status = ST_OVERFLOW;
        end else begin
          f = longint'(c.feature_value);
          base = (feat_pos + 1) * NUM_CLASSES;
          if (feat_pos == 0) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
              scores[k] = sat_score(longint'(weights[k]) * (longint'(1) <<< FEAT_FRAC_BITS));
            end
          end
          for (int k = 0; k < NUM_CLASSES; k++) begin
            scores[k] = sat_score(scores[k] + f * longint'(weights[base + k]));
          end
          feat_pos++;
          if (c.last_feature) begin
            best = 0;
            for (int k = 1; k < kin; k++) begin
              if (scores[k] > scores[best]) best = k;
            end
            lab = c.label;
            r.predicted_class = CLASS_W'(best);
            r.prediction_valid = 1'b1;
            if (lab >= kin) begin
              r.status = ST_BAD_LABEL;
            end else begin
              r.correct = (lab == best);
              confusion[lab * NUM_CLASSES + best] = sat_inc(confusion[lab * NUM_CLASSES + best]);
              row_tot[lab] = sat_inc(row_tot[lab]);
              n_samples = sat_inc(n_samples);
              if (r.correct) n_correct = sat_inc(n_correct);
            end
            feat_pos = 0;
          end
        end
      end
      OP_READ_CELL: begin
        if (c.read_true_class >= kin || c.read_predicted_class >= kin) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.cell_count = confusion[c.read_true_class * NUM_CLASSES + c.read_predicted_class];
          r.row_total = row_tot[c.read_true_class];
        end
      end
      default: clear_counts();
    endcase
    r.correct_total = n_correct;
    r.sample_total = n_samples;
    outcome_q = {outcome_q, r};
  endfunction

  function automatic void check_field(input string name, input logic [COUNT_WIDTH-1:0] want,
                                      input logic [COUNT_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result();
    out_item_t want;
    if (outcome_q.size() == 0) begin
      $display("%0t: result item with nothing pending, actual status %0d", $time,
               out_ch.status);
      errors++;
    end else begin
      want = outcome_q.pop_front();
      check_field("predicted_class", want.predicted_class, out_ch.predicted_class);
      check_field("prediction_valid", want.prediction_valid, out_ch.prediction_valid);
      check_field("correct", want.correct, out_ch.correct);
      check_field("cell_count", want.cell_count, out_ch.cell_count);
      check_field("row_total", want.row_total, out_ch.row_total);
      check_field("correct_total", want.correct_total, out_ch.correct_total);
      check_field("sample_total", want.sample_total, out_ch.sample_total);
      check_field("status", want.status, out_ch.status);
    end
  endfunction

  // input side: hold the item until taken, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        classify(drive_cmd);
        items_unaccepted--;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          drive_cmd = feed_q.pop_front();
          in_ch.valid                <= 1'b1;
          in_ch.opcode               <= drive_cmd.opcode;
          in_ch.feature_index        <= drive_cmd.feature_index;
          in_ch.weight_class         <= drive_cmd.weight_class;
          in_ch.weight_value         <= drive_cmd.weight_value;
          in_ch.feature_value        <= drive_cmd.feature_value;
          in_ch.last_feature         <= drive_cmd.last_feature;
          in_ch.label                <= drive_cmd.label;
          in_ch.read_true_class      <= drive_cmd.read_true_class;
          in_ch.read_predicted_class <= drive_cmd.read_predicted_class;
          if (idle_on && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 18);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side: check each item, stall in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(1, 18) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("linear_classifier_confusion_tb NOT OK");
      $finish;
    end
  end

  function automatic cmd_t rand_cmd(input opcode_t op);
    cmd_t c;
    c.opcode               = op;
    c.feature_index        = ROW_W'($urandom);
    c.weight_class         = CLASS_W'($urandom);
    c.weight_value         = WEIGHT_WIDTH'($urandom);
    c.feature_value        = FEATURE_WIDTH'($urandom);
    c.last_feature         = 1'($urandom);
    c.label                = CLASS_W'($urandom);
    c.read_true_class      = CLASS_W'($urandom);
    c.read_predicted_class = CLASS_W'($urandom);
    return c;
  endfunction

  function automatic void push_cmd(input cmd_t c);
    feed_q = {feed_q, c};
    items_unaccepted++;
  endfunction

  function automatic void push_write(input int row, input int col, input int value);
    cmd_t c;
    c = rand_cmd(OP_WRITE_WEIGHT);
    c.feature_index = ROW_W'(row);
    c.weight_class = CLASS_W'(col);
    c.weight_value = WEIGHT_WIDTH'(value);
    push_cmd(c);
  endfunction

  function automatic void push_feature(input int value, input bit last, input int lab);
    cmd_t c;
    c = rand_cmd(OP_FEATURE);
    c.feature_value = FEATURE_WIDTH'(value);
    c.last_feature = last;
    c.label = CLASS_W'(lab);
    gen_pos = last ? 0 : gen_pos + 1;
    push_cmd(c);
  endfunction

  function automatic void push_read(input int true_class, input int pred_class);
    cmd_t c;
    c = rand_cmd(OP_READ_CELL);
    c.read_true_class = CLASS_W'(true_class);
    c.read_predicted_class = CLASS_W'(pred_class);
    push_cmd(c);
  endfunction

  function automatic int weight_pick();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32767;
      2: return -32768;
      3: return 4096;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int feature_pick();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32767;
      2: return -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int class_pick(input int kin);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, kin - 1);
  endfunction

  // mostly whole samples with random content, plus reads, writes, clears and noise
  function automatic void push_random(input int n);
    int sent;
    int len;
    int pick;
    int kin;
    sent = 0;
    kin = classes_now();
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          push_feature(feature_pick(), i == len - 1, class_pick(kin));
        end
        sent += len;
      end else begin
        if (pick < 75) begin
          push_read(class_pick(kin), class_pick(kin));
        end else if (pick < 90) begin
          push_write(($urandom_range(0, 9) == 0) ? $urandom_range(1025, 2047)
                                                 : $urandom_range(0, NUM_FEATURES),
                     $urandom_range(0, 15), weight_pick());
        end else if (pick < 94) begin
          push_cmd(rand_cmd(OP_CLEAR));
        end else begin
          // stray feature; end it if a sample is already open to stay in the loaded rows
          push_feature(feature_pick(), (gen_pos > 0) || ($urandom_range(0, 1) == 1),
                       $urandom_range(0, 15));
        end
        sent++;
      end
    end
  endfunction

  task automatic drain();
    while (items_unaccepted != 0 || outcome_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_class_count(input int value);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= KIN_W'(value);
    class_count_shadow = KIN_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_FEATURE;
    in_ch.feature_index = '0;
    in_ch.weight_class = '0;
    in_ch.weight_value = '0;
    in_ch.feature_value = '0;
    in_ch.last_feature = 1'b0;
    in_ch.label = '0;
    in_ch.read_true_class = '0;
    in_ch.read_predicted_class = '0;
    out_ch.ready = 1'b0;
    foreach (weights[i]) weights[i] = '0;
    foreach (scores[i]) scores[i] = 0;
    feat_pos = 0;
    clear_counts();
    class_count_shadow = CLASS_COUNT_RESET;
    items_unaccepted = 0;
    gen_pos = 0;
    send_gap = 0;
    hold_left = 0;
    quiet = 0;
    errors = 0;
    idle_on = 1'b1;
    long_hold_req = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // counts right after reset, bad read indexes, bad weight rows
    push_read(0, 0);
    push_read(9, 9);
    push_read(10, 0);
    push_read(15, 15);
    push_cmd(rand_cmd(OP_CLEAR));
    push_write(1025, 3, 1234);
    push_write(2047, 15, -1);

    // load the rows that samples reach; bias row from two values so that ties occur
    for (int row = 0; row < LOADED_ROWS; row++) begin
      for (int col = 0; col < NUM_CLASSES; col++) begin
        push_write(row, col, (row == 0) ? (($urandom_range(0, 1) == 1) ? 4096 : 0)
                                        : weight_pick());
      end
    end

    // extreme products, ties, top label, bad label
    push_write(1, 0, -32768);
    push_write(1, 15, 32767);
    push_feature(-32768, 1'b1, 0);
    push_feature(32767, 1'b1, 9);
    push_feature(0, 1'b1, 3);
    push_feature(100, 1'b1, 15);
    // a sample keeps going across clear, read and weight write
    push_feature(5, 1'b0, 0);
    push_cmd(rand_cmd(OP_CLEAR));
    push_read(0, 0);
    push_write(2, 4, 123);
    push_feature(-7, 1'b1, 2);
    push_read(2, 0);
    push_read(9, 10);

    push_feature(256, 1'b1, 4);
    push_read(1, 1);

    push_random(40);

    set_class_count(0);
    push_random(40);
    set_class_count(16);
    push_random(60);
    // long receiver stall while the sender keeps offering
    while (items_unaccepted > 40) @(negedge clk);
    long_hold_req = 1'b1;
    set_class_count(31);
    push_random(40);
    set_class_count(2);
    push_random(40);
    set_class_count(1);
    push_random(35);
    set_class_count(17);
    push_random(35);
    set_class_count(5);
    push_random(30);

    set_class_count($urandom_range(0, 31));
    idle_on = 1'b0;
    push_random(30);
    drain();

    if (errors == 0) begin
      $display("linear_classifier_confusion_tb OK");
    end else begin
      $display("linear_classifier_confusion_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/lcc_pkg.sv
design/lcc_if.sv
design/lcc_argmax.sv
design/lcc_fifo.sv
design/linear_classifier_confusion.sv
tb/sv/linear_classifier_confusion_tb.sv
